/* sv/foc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_pkg
// shared types, constants and the quarter-wave sine table for the
// voltage-mode commutator
// ----------------------------------------------------------------------------
package foc_pkg;

  // pipeline depth, accept to result
  localparam int NUM_STAGES = 8;

  // field widths
  localparam int ANGLE_W  = 12;
  localparam int SPEED_W  = 19;
  localparam int TORQUE_W = 16;
  localparam int DUTY_W   = 16;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // fixed point constants, q15
  localparam int UQ_LIMIT     = 18919;
  localparam int SQRT3_OVER_2 = 28378;
  localparam int HALF_Q15     = 16384;
  localparam int ONE_Q15      = 32768;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // register reset values
  localparam logic        RST_DIRECTION_NEGATIVE = 1'b0;
  localparam logic [15:0] RST_PHASE_OFFSET = 16'd0;
  localparam logic [3:0]  RST_PAIR_COUNT   = 4'd7;
  localparam logic [15:0] RST_TORQUE_GAIN  = 16'd41073;
  localparam logic [11:0] RST_BEMF_GAIN    = 12'd1121;
  localparam logic [15:0] RST_PWM_PERIOD   = 16'd1600;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION_NEGATIVE = 3'd0,
    REG_PHASE_OFFSET       = 3'd1,
    REG_PAIR_COUNT         = 3'd2,
    REG_TORQUE_GAIN        = 3'd3,
    REG_BEMF_GAIN          = 3'd4,
    REG_PWM_PERIOD         = 3'd5
  } reg_index_t;

  localparam int SINE_TABLE_ENTRIES = 65;

  localparam logic [15:0] QUARTER_SINE [0:SINE_TABLE_ENTRIES-1] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32768
  };

  // interpolation end points of one table segment
  typedef struct packed {
    logic signed [16:0] lo;
    logic signed [16:0] hi;
  } sine_pair_t;

  // quadrant folding of the quarter-wave table, idx is phase[15:8]
  function automatic sine_pair_t sine_pair(input logic [7:0] idx);
    logic [6:0] a0;
    logic [6:0] a1;
    logic [6:0] b0;
    logic [6:0] b1;
    logic signed [16:0] ta0;
    logic signed [16:0] ta1;
    logic signed [16:0] tb0;
    logic signed [16:0] tb1;
    sine_pair_t r;
    a0  = {1'b0, idx[5:0]};
    a1  = a0 + 7'd1;
    b0  = 7'd64 - a0;
    b1  = 7'd63 - a0;
    ta0 = $signed({1'b0, QUARTER_SINE[a0]});
    ta1 = $signed({1'b0, QUARTER_SINE[a1]});
    tb0 = $signed({1'b0, QUARTER_SINE[b0]});
    tb1 = $signed({1'b0, QUARTER_SINE[b1]});
    case (idx[7:6])
      2'd0: begin
        r.lo = ta0;
        r.hi = ta1;
      end
      2'd1: begin
        r.lo = tb0;
        r.hi = tb1;
      end
      2'd2: begin
        r.lo = -ta0;
        r.hi = -ta1;
      end
      default: begin
        r.lo = -tb0;
        r.hi = -tb1;
      end
    endcase
    return r;
  endfunction

endpackage

/* sv/foc_voltage_svpwm_commutator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_voltage_svpwm_commutator
// voltage-mode field oriented commutator with min/max injection space-vector
// pwm, one sample in, three phase compare counts out
// ----------------------------------------------------------------------------
// path: an accepted request passes through the eight register stages in order to m_tvalid
// throughput: one request per cycle while m_tready is high, the eight register stages each hold one
//   request and advance independently, so bubbles close up under a stall
// reset: rst (synchronous, active high) empties every stage and loads the
//   configuration registers with their default values; payload is not reset

module foc_voltage_svpwm_commutator (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [11:0] angle_count, [30:12] shaft_speed, [46:31] torque_target, [47] zero
  input  logic [foc_pkg::S_DATA_W-1:0]       s_tdata,
  // [0] sample_valid
  input  logic                               s_tuser,
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c
  output logic [foc_pkg::M_DATA_W-1:0]       m_tdata,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [foc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [foc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NS = foc_pkg::NUM_STAGES;

  localparam logic signed [33:0] UQ_HI = 34'(foc_pkg::UQ_LIMIT);
  localparam logic signed [33:0] UQ_LO = -UQ_HI;
  localparam logic signed [16:0] K_SQRT3 = 17'(foc_pkg::SQRT3_OVER_2);
  localparam logic signed [19:0] HALF_20 = 20'(foc_pkg::HALF_Q15);
  localparam logic signed [19:0] ONE_20  = 20'(foc_pkg::ONE_Q15);
  localparam logic [32:0] ROUND_33 = 33'(foc_pkg::HALF_Q15);

  // --------------------------------------------------------------------------
  // configuration registers, always ready
  // --------------------------------------------------------------------------
  logic        direction_negative;
  logic [15:0] phase_offset;
  logic [3:0]  pair_count;
  logic [15:0] torque_gain;
  logic [11:0] bemf_gain;
  logic [15:0] pwm_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_negative <= foc_pkg::RST_DIRECTION_NEGATIVE;
      phase_offset       <= foc_pkg::RST_PHASE_OFFSET;
      pair_count         <= foc_pkg::RST_PAIR_COUNT;
      torque_gain        <= foc_pkg::RST_TORQUE_GAIN;
      bemf_gain          <= foc_pkg::RST_BEMF_GAIN;
      pwm_period         <= foc_pkg::RST_PWM_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        foc_pkg::REG_DIRECTION_NEGATIVE: direction_negative <= cfg_data[0];
        foc_pkg::REG_PHASE_OFFSET:       phase_offset       <= cfg_data;
        foc_pkg::REG_PAIR_COUNT:         pair_count         <= cfg_data[3:0];
        foc_pkg::REG_TORQUE_GAIN:        torque_gain        <= cfg_data;
        foc_pkg::REG_BEMF_GAIN:          bemf_gain          <= cfg_data[11:0];
        foc_pkg::REG_PWM_PERIOD:         pwm_period         <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage occupancy and per-stage advance
  // a stage may load when it is empty or its content moves on this cycle,
  // so a stalled output only backs up as far as the first empty stage
  // --------------------------------------------------------------------------
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: electrical phase and the two uq products
  // --------------------------------------------------------------------------
  logic [11:0]        in_angle;
  logic [18:0]        in_speed;
  logic [15:0]        in_torque;
  logic [19:0]        pp_prod;
  logic [15:0]        ph_dir;
  logic [15:0]        ph_in;
  logic signed [32:0] tq_in;
  logic signed [31:0] sp_in;

  assign in_angle  = s_tdata[11:0];
  assign in_speed  = s_tdata[30:12];
  assign in_torque = s_tdata[46:31];

  always_comb begin
    pp_prod = pair_count * {in_angle, 4'b0000};
    ph_dir  = direction_negative ? (16'd0 - pp_prod[15:0]) : pp_prod[15:0];
    ph_in   = ph_dir - phase_offset;
    tq_in   = $signed(in_torque) * $signed({1'b0, torque_gain});
    sp_in   = $signed(in_speed) * $signed({1'b0, bemf_gain});
    // missing encoder sample: zero volts at phase zero
    if (!s_tuser) begin
      ph_in = '0;
      tq_in = '0;
      sp_in = '0;
    end
  end

  logic [15:0]        st1_ph;
  logic signed [32:0] st1_tq;
  logic signed [31:0] st1_sp;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st1_ph <= ph_in;
      st1_tq <= tq_in;
      st1_sp <= sp_in;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: uq sum and clamp, sine and cosine table lookup
  // --------------------------------------------------------------------------
  logic signed [31:0] sp_sgn;
  logic signed [32:0] tq_sh;
  logic signed [31:0] sp_sh;
  logic signed [33:0] uq_sum;
  logic signed [15:0] uq_clamped;
  logic [15:0]        ph_cos;
  foc_pkg::sine_pair_t pair_s;
  foc_pkg::sine_pair_t pair_c;

  always_comb begin
    sp_sgn = direction_negative ? -st1_sp : st1_sp;
    tq_sh  = st1_tq >>> 8;
    sp_sh  = sp_sgn >>> 14;
    uq_sum = 34'(tq_sh) + 34'(sp_sh);
    if (uq_sum > UQ_HI) begin
      uq_clamped = UQ_HI[15:0];
    end else if (uq_sum < UQ_LO) begin
      uq_clamped = UQ_LO[15:0];
    end else begin
      uq_clamped = uq_sum[15:0];
    end
    ph_cos = st1_ph + foc_pkg::QUARTER_TURN;
    pair_s = foc_pkg::sine_pair(st1_ph[15:8]);
    pair_c = foc_pkg::sine_pair(ph_cos[15:8]);
  end

  logic signed [15:0]  st2_uq;
  foc_pkg::sine_pair_t st2_s;
  foc_pkg::sine_pair_t st2_c;
  logic [7:0]          st2_s_frac;
  logic [7:0]          st2_c_frac;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      st2_uq     <= uq_clamped;
      st2_s      <= pair_s;
      st2_c      <= pair_c;
      st2_s_frac <= st1_ph[7:0];
      st2_c_frac <= ph_cos[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: linear interpolation between table points
  // --------------------------------------------------------------------------
  logic signed [17:0] s_diff;
  logic signed [17:0] c_diff;
  logic signed [26:0] s_prod;
  logic signed [26:0] c_prod;
  logic signed [26:0] s_interp;
  logic signed [26:0] c_interp;

  always_comb begin
    s_diff   = 18'(st2_s.hi) - 18'(st2_s.lo);
    c_diff   = 18'(st2_c.hi) - 18'(st2_c.lo);
    s_prod   = s_diff * $signed({1'b0, st2_s_frac});
    c_prod   = c_diff * $signed({1'b0, st2_c_frac});
    s_interp = 27'(st2_s.lo) + (s_prod >>> 8);
    c_interp = 27'(st2_c.lo) + (c_prod >>> 8);
  end

  logic signed [16:0] st3_sin;
  logic signed [16:0] st3_cos;
  logic signed [15:0] st3_uq;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      st3_sin <= s_interp[16:0];
      st3_cos <= c_interp[16:0];
      st3_uq  <= st2_uq;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: inverse park with d = 0
  // --------------------------------------------------------------------------
  logic signed [32:0] a_prod;
  logic signed [32:0] b_prod;
  logic signed [32:0] alpha_w;
  logic signed [32:0] beta_w;

  always_comb begin
    a_prod  = st3_sin * st3_uq;
    b_prod  = st3_cos * st3_uq;
    alpha_w = -(a_prod >>> 15);
    beta_w  = b_prod >>> 15;
  end

  logic signed [16:0] st4_alpha;
  logic signed [16:0] st4_beta;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      st4_alpha <= alpha_w[16:0];
      st4_beta  <= beta_w[16:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: inverse clarke
  // --------------------------------------------------------------------------
  logic signed [33:0] k_prod;
  logic signed [17:0] k_val;
  logic signed [17:0] half_val;
  logic signed [17:0] pa_w;
  logic signed [17:0] pb_w;
  logic signed [17:0] pc_w;

  always_comb begin
    k_prod   = st4_beta * K_SQRT3;
    k_val    = k_prod[32:15];
    half_val = 18'(st4_alpha >>> 1);
    pa_w     = 18'(st4_alpha);
    pb_w     = k_val - half_val;
    pc_w     = -half_val - k_val;
  end

  logic signed [17:0] st5_pa;
  logic signed [17:0] st5_pb;
  logic signed [17:0] st5_pc;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      st5_pa <= pa_w;
      st5_pb <= pb_w;
      st5_pc <= pc_w;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: min/max zero-sequence offset
  // --------------------------------------------------------------------------
  logic signed [17:0] p_lo;
  logic signed [17:0] p_hi;
  logic signed [18:0] mid_sum;
  logic signed [19:0] off_w;

  always_comb begin
    p_lo = st5_pa;
    p_hi = st5_pa;
    if (st5_pb < p_lo) p_lo = st5_pb;
    if (st5_pc < p_lo) p_lo = st5_pc;
    if (st5_pb > p_hi) p_hi = st5_pb;
    if (st5_pc > p_hi) p_hi = st5_pc;
    mid_sum = 19'(p_hi) + 19'(p_lo);
    off_w   = HALF_20 - 20'(mid_sum >>> 1);
  end

  logic signed [17:0] st6_p [3];
  logic signed [19:0] st6_off;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      st6_p[0] <= st5_pa;
      st6_p[1] <= st5_pb;
      st6_p[2] <= st5_pc;
      st6_off  <= off_w;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: offset and clamp each phase to 0..1.0
  // --------------------------------------------------------------------------
  logic signed [19:0] ph_sum [3];
  logic [15:0]        ph_sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ph_sum[i] = 20'(st6_p[i]) + st6_off;
      if (ph_sum[i] < 0) begin
        ph_sat[i] = '0;
      end else if (ph_sum[i] > ONE_20) begin
        ph_sat[i] = ONE_20[15:0];
      end else begin
        ph_sat[i] = ph_sum[i][15:0];
      end
    end
  end

  logic [15:0] st7_p [3];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        st7_p[i] <= ph_sat[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: scale to timer compare counts with rounding, output register
  // --------------------------------------------------------------------------
  logic [32:0] cnt_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cnt_w[i] = 33'(st7_p[i]) * 33'(pwm_period) + ROUND_33;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        m_tdata[i*foc_pkg::DUTY_W +: foc_pkg::DUTY_W] <= cnt_w[i][30:15];
      end
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[0])
    else $error("accepted request did not enter the first stage");

  a_duty_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] <= pwm_period) && (m_tdata[31:16] <= pwm_period)
                 && (m_tdata[47:32] <= pwm_period))
    else $error("duty above pwm period");

endmodule

/* tb/foc_voltage_svpwm_commutator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_voltage_svpwm_commutator_checker
// watches the sample, duty and configuration channels, predicts the three
// phase compare counts of every accepted sample and compares them in order
// ----------------------------------------------------------------------------
module foc_voltage_svpwm_commutator_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [foc_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [foc_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [foc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [foc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             results_seen,
  output int                             mismatches
);

  // shadow copy of the configuration registers
  logic        dir_neg;
  logic [15:0] zero_ph;
  logic [3:0]  pair_count;
  logic [15:0] torque_gain;
  logic [11:0] bemf_gain;
  logic [15:0] pwm_period;

  // {duty_c, duty_b, duty_a}, duty_a in the low bits as on m_tdata
  logic [3*foc_pkg::DUTY_W-1:0] expected_duties [$];

  string duty_name [3] = '{"duty_a", "duty_b", "duty_c"};

  initial begin
    results_seen = 0;
    mismatches   = 0;
  end

  function automatic longint sine_at(input logic [15:0] ph);
    int     base;
    longint lo;
    longint hi;
    longint frac;
    base = ph[13:8];
    frac = ph[7:0];
    // second and fourth quadrants run the table backwards
    if (!ph[14]) begin
      lo = foc_pkg::QUARTER_SINE[base];
      hi = foc_pkg::QUARTER_SINE[base + 1];
    end else begin
      lo = foc_pkg::QUARTER_SINE[64 - base];
      hi = foc_pkg::QUARTER_SINE[63 - base];
    end
    // second half of the turn is negative
    if (ph[15]) begin
      lo = -lo;
      hi = -hi;
    end
    return lo + (((hi - lo) * frac) >>> 8);
  endfunction

  function automatic longint q15_mul(input longint a, input longint b);
    return (a * b) >>> 15;
  endfunction

  function automatic logic [15:0] duty_count(input longint p);
    longint per;
    longint cnt;
    per = pwm_period;
    if (p < 0) p = 0;
    else if (p > foc_pkg::ONE_Q15) p = foc_pkg::ONE_Q15;
    cnt = (p * per + foc_pkg::HALF_Q15) >>> 15;
    return cnt[15:0];
  endfunction

  function automatic logic [3*foc_pkg::DUTY_W-1:0] predict_duties(
    input logic [foc_pkg::ANGLE_W-1:0]  ang,
    input logic [foc_pkg::SPEED_W-1:0]  spd,
    input logic [foc_pkg::TORQUE_W-1:0] trq,
    input logic                         vld
  );
    logic [15:0] ph;
    logic [15:0] mech;
    longint speed, torque, uq, s, c, alpha, beta, half, k;
    longint pa, pb, pc, lo, hi, off;
    if (!vld) begin
      // no sample: zero voltage at phase zero
      ph = '0;
      uq = 0;
    end else begin
      mech = {ang, 4'b0000};
      ph   = pair_count * mech;
      if (dir_neg) ph = 16'h0000 - ph;
      ph     = ph - zero_ph;
      speed  = $signed(spd);
      torque = $signed(trq);
      if (dir_neg) speed = -speed;
      uq = ((torque * longint'(torque_gain)) >>> 8)
         + ((speed * longint'(bemf_gain)) >>> 14);
    end
    if (uq > foc_pkg::UQ_LIMIT) uq = foc_pkg::UQ_LIMIT;
    else if (uq < -foc_pkg::UQ_LIMIT) uq = -foc_pkg::UQ_LIMIT;
    s = sine_at(ph);
    c = sine_at(ph + foc_pkg::QUARTER_TURN);
    // inverse park with d = 0, then inverse clarke
    alpha = -q15_mul(s, uq);
    beta  = q15_mul(c, uq);
    half  = alpha >>> 1;
    k     = q15_mul(foc_pkg::SQRT3_OVER_2, beta);
    pa = alpha;
    pb = -half + k;
    pc = -half - k;
    lo = pa;
    hi = pa;
    if (pb < lo) lo = pb;
    if (pc < lo) lo = pc;
    if (pb > hi) hi = pb;
    if (pc > hi) hi = pc;
    // min/max zero-sequence injection centers the phases on half duty
    off = foc_pkg::HALF_Q15 - ((hi + lo) >>> 1);
    return {duty_count(pc + off), duty_count(pb + off), duty_count(pa + off)};
  endfunction

  always @(posedge clk) begin
    logic [3*foc_pkg::DUTY_W-1:0] want;
    logic [3*foc_pkg::DUTY_W-1:0] got;
    if (rst) begin
      dir_neg     <= foc_pkg::RST_DIRECTION_NEGATIVE;
      zero_ph     <= foc_pkg::RST_PHASE_OFFSET;
      pair_count  <= foc_pkg::RST_PAIR_COUNT;
      torque_gain <= foc_pkg::RST_TORQUE_GAIN;
      bemf_gain   <= foc_pkg::RST_BEMF_GAIN;
      pwm_period  <= foc_pkg::RST_PWM_PERIOD;
      expected_duties.delete();
      results_seen <= 0;
    end else begin
      // results first: one leaving now belongs to an earlier request
      if (m_tvalid && m_tready) begin
        got = m_tdata[3*foc_pkg::DUTY_W-1:0];
        results_seen <= results_seen + 1;
        if (expected_duties.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: unexpected result, actual %h", $realtime, got);
        end else begin
          want = expected_duties.pop_front();
          for (int f = 0; f < 3; f++) begin
            if (got[f*foc_pkg::DUTY_W +: foc_pkg::DUTY_W]
                !== want[f*foc_pkg::DUTY_W +: foc_pkg::DUTY_W]) begin
              mismatches = mismatches + 1;
              if (mismatches <= 10)
                $display("%0t: %s expected %0d actual %0d", $realtime, duty_name[f],
                         want[f*foc_pkg::DUTY_W +: foc_pkg::DUTY_W],
                         got[f*foc_pkg::DUTY_W +: foc_pkg::DUTY_W]);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_duties.push_back(predict_duties(
          s_tdata[foc_pkg::ANGLE_W-1:0],
          s_tdata[foc_pkg::ANGLE_W +: foc_pkg::SPEED_W],
          s_tdata[foc_pkg::ANGLE_W+foc_pkg::SPEED_W +: foc_pkg::TORQUE_W],
          s_tuser));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          foc_pkg::REG_DIRECTION_NEGATIVE: dir_neg     <= cfg_data[0];
          foc_pkg::REG_PHASE_OFFSET:       zero_ph     <= cfg_data;
          foc_pkg::REG_PAIR_COUNT:         pair_count  <= cfg_data[3:0];
          foc_pkg::REG_TORQUE_GAIN:        torque_gain <= cfg_data;
          foc_pkg::REG_BEMF_GAIN:          bemf_gain   <= cfg_data[11:0];
          foc_pkg::REG_PWM_PERIOD:         pwm_period  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/foc_voltage_svpwm_commutator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_voltage_svpwm_commutator_tb
// drives encoder samples and configuration writes into the commutator under
// random stalls on both streams; the checker beside it predicts and compares
// every duty triple, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module foc_voltage_svpwm_commutator_tb;

  localparam int CLK_PERIOD  = 20;
  localparam int RST_CYCLES  = 9;
  localparam int CYCLE_LIMIT = 200000;
  // receiver hold-off, long enough to fill every pipeline stage
  localparam int LONG_HOLD   = 200;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int NUM_PHASES  = 8;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  // [11:0] angle_count, [30:12] shaft_speed, [46:31] torque_target, [47] zero
  logic [foc_pkg::S_DATA_W-1:0]   s_tdata = '0;
  // [0] sample_valid
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c
  logic [foc_pkg::M_DATA_W-1:0]   m_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [foc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [foc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int   results_seen;
  int   mismatches;
  int   items_sent = 0;
  int   cycle_count = 0;

  // receiver control: a toggle on hold_token asks for one long hold-off,
  // steady turns off all random idling for the tail of the run
  logic hold_token = 1'b0;
  logic hold_seen  = 1'b0;
  logic steady     = 1'b0;
  int   rx_gap     = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  foc_voltage_svpwm_commutator uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  foc_voltage_svpwm_commutator_checker duty_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .results_seen (results_seen),
    .mismatches   (mismatches)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // duty receiver: random stall bursts, one long hold-off on request, none
  // at all once steady is set
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      m_tready  <= 1'b0;
      rx_gap    <= LONG_HOLD - 1;
    end else if (rx_gap > 0) begin
      m_tready <= 1'b0;
      rx_gap   <= rx_gap - 1;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      rx_gap   <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // offer one sample and hold it until accepted; s_tvalid stays high after
  // the handshake so back-to-back requests never drop it
  task automatic send_sample(
    input logic [foc_pkg::ANGLE_W-1:0]  ang,
    input logic [foc_pkg::SPEED_W-1:0]  spd,
    input logic [foc_pkg::TORQUE_W-1:0] trq,
    input logic                         vld
  );
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, trq, spd, ang};
    s_tuser  <= vld;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // sender stops and waits until every sample has come back as duties
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  // write all register indexes in one burst, the two unused ones too;
  // only called with the pipeline empty
  task automatic program_config(
    input logic [15:0] dir_v,
    input logic [15:0] zero_v,
    input logic [15:0] pp_v,
    input logic [15:0] tg_v,
    input logic [15:0] bg_v,
    input logic [15:0] per_v
  );
    logic [15:0] vals [0:(1 << foc_pkg::CFG_IDX_W) - 1];
    for (int i = 0; i < (1 << foc_pkg::CFG_IDX_W); i++) vals[i] = 16'($urandom);
    vals[foc_pkg::REG_DIRECTION_NEGATIVE] = dir_v;
    vals[foc_pkg::REG_PHASE_OFFSET]       = zero_v;
    vals[foc_pkg::REG_PAIR_COUNT]         = pp_v;
    vals[foc_pkg::REG_TORQUE_GAIN]        = tg_v;
    vals[foc_pkg::REG_BEMF_GAIN]          = bg_v;
    vals[foc_pkg::REG_PWM_PERIOD]         = per_v;
    for (int i = 0; i < (1 << foc_pkg::CFG_IDX_W); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[foc_pkg::CFG_IDX_W-1:0];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // field extremes and the no-sample case, back to back
  task automatic send_corners();
    send_sample('0, '0, '0, 1'b1);
    send_sample('1, 19'h3FFFF, 16'h7FFF, 1'b1);
    send_sample('0, 19'h40000, 16'h8000, 1'b1);
    send_sample(12'd2048, '1, 16'd1, 1'b1);
    send_sample(12'($urandom), 19'($urandom), 16'($urandom), 1'b0);
    send_sample('1, '0, '0, 1'b0);
  endtask

  task automatic run_random(input int n, input bit allow_idle);
    logic [foc_pkg::ANGLE_W-1:0]  ang;
    logic [foc_pkg::SPEED_W-1:0]  spd;
    logic [foc_pkg::TORQUE_W-1:0] trq;
    logic                         vld;
    int                           gap;
    for (int i = 0; i < n; i++) begin
      if (allow_idle && !steady && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 5);
        s_tvalid <= 1'b0;
        s_tdata  <= {16'($urandom), $urandom};
        s_tuser  <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
      ang = 12'($urandom_range(0, (1 << foc_pkg::ANGLE_W) - 1));
      // mostly moderate speed and torque so uq stays inside the clamp and
      // the whole sine/cosine interpolation is exercised
      if ($urandom_range(0, 3) == 0) spd = 19'($urandom);
      else spd = 19'($urandom_range(0, 8000)) - 19'd4000;
      if ($urandom_range(0, 3) == 0) trq = 16'($urandom);
      else trq = 16'($urandom_range(0, 300)) - 16'd150;
      vld = ($urandom_range(0, 9) != 0);
      send_sample(ang, spd, trq, vld);
    end
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset configuration: corners, then a sweep
    // across all four quadrants of the electrical phase
    send_corners();
    for (int i = 0; i < 16; i++)
      send_sample(12'(i * 256 + i * 37), 19'd1000, 16'd90, 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_all_results();
      case (phase)
        0: ;  // keep reset values
        // all registers at their upper end
        1: program_config(16'd1, 16'hFFFF, 16'd15, 16'hFFFF, 16'h0FFF, 16'hFFFF);
        // all at zero: pole pairs zero and period zero
        2: program_config('0, '0, '0, '0, '0, '0);
        // values wider than the registers, period of one count
        3: program_config(16'hFFFE, 16'($urandom), 16'hFFF3, 16'($urandom),
                          16'hFFFF, 16'd1);
        default: program_config(16'($urandom_range(0, 1)), 16'($urandom),
                                16'($urandom_range(1, 15)), 16'($urandom),
                                16'($urandom_range(0, 4095)),
                                16'($urandom_range(1, 65535)));
      endcase
      if (phase == NUM_PHASES - 1) steady <= 1'b1;
      if (phase != 0) send_corners();
      if (phase == 4) begin
        // receiver holds off while samples keep coming, the pipeline fills
        // and must back-pressure the sender
        hold_token <= ~hold_token;
        run_random(40, 1'b0);
        run_random(RANDOM_PER_PHASE - 40, 1'b1);
      end else begin
        run_random(RANDOM_PER_PHASE, 1'b1);
      end
    end

    wait_all_results();
    // let any stray extra result show up
    repeat (foc_pkg::NUM_STAGES + 4) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
sv/foc_pkg.sv
sv/foc_voltage_svpwm_commutator.sv
tb/foc_voltage_svpwm_commutator_checker.sv
tb/foc_voltage_svpwm_commutator_tb.sv
